// File: design/clpf_pkg.sv
// ----------------------------------------------------------------------------
// clpf_pkg
// Shared types, widths and helpers for the cascaded first-order lowpass unit.
// ----------------------------------------------------------------------------
package clpf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 24;
    localparam int COEF_W   = 17;
    localparam int ORDER_W  = 3;
    localparam int DATA_W   = 32;
    localparam int SUM_W    = DATA_W + 1;
    localparam int OPA_W    = 24;
    localparam int OPB_W    = SUM_W;
    localparam int PROD_W   = OPA_W + OPB_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int FRAC_W   = 16;
    localparam int SHIFT_W  = ACC_W - FRAC_W;
    localparam int ADDR_W   = 4;
    localparam int PDATA_W  = 32;

    localparam logic signed [GAIN_W-1:0]  GAIN_RESET  = 24'sh010000;
    localparam logic        [ORDER_W-1:0] ORDER_RESET = 3'd7;

    localparam logic signed [SHIFT_W-1:0] SAT_HI =
        {{(SHIFT_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [SHIFT_W-1:0] SAT_LO =
        {{(SHIFT_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_FEEDBACK    = 2'd0,
        REG_FEEDFORWARD = 2'd1,
        REG_GAIN        = 2'd2,
        REG_ORDER       = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAIN,
        ST_FF,
        ST_ACC
    } state_t;

    typedef enum logic [1:0] {
        MUL_GAIN,
        MUL_FB,
        MUL_FF
    } mul_sel_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] c1;
        logic        [COEF_W-1:0] c2;
        logic signed [GAIN_W-1:0] gain;
        logic        [ORDER_W-1:0] order;
    } cfg_t;

    typedef struct packed {
        logic     in_ready;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clr;
        logic     acc_load;
        logic     stage_clr;
        logic     stage_inc;
        logic     rd_next;
        logic     hold_load;
        logic     commit;
        logic     out_load;
    } ctrl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SHIFT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < SAT_LO) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/clpf_cfg.sv
// ----------------------------------------------------------------------------
// clpf_cfg
// APB register file holding coefficients, input gain and filter order.
// ----------------------------------------------------------------------------
module clpf_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [clpf_pkg::ADDR_W-1:0]      paddr,
    input  logic [clpf_pkg::PDATA_W-1:0]     pwdata,
    output logic [clpf_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    output clpf_pkg::cfg_t                   cfg
);

    clpf_pkg::cfg_t    cfg_reg;
    logic              wr_en;
    clpf_pkg::reg_idx_t idx;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = clpf_pkg::reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.c1    <= '0;
            cfg_reg.c2    <= '0;
            cfg_reg.gain  <= clpf_pkg::GAIN_RESET;
            cfg_reg.order <= clpf_pkg::ORDER_RESET;
        end else if (wr_en) begin
            case (idx)
                clpf_pkg::REG_FEEDBACK: begin
                    cfg_reg.c1 <= pwdata[clpf_pkg::COEF_W-1:0];
                end
                clpf_pkg::REG_FEEDFORWARD: begin
                    cfg_reg.c2 <= pwdata[clpf_pkg::COEF_W-1:0];
                end
                clpf_pkg::REG_GAIN: begin
                    cfg_reg.gain <= pwdata[clpf_pkg::GAIN_W-1:0];
                end
                clpf_pkg::REG_ORDER: begin
                    cfg_reg.order <= pwdata[clpf_pkg::ORDER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            clpf_pkg::REG_FEEDBACK: begin
                prdata = {{(clpf_pkg::PDATA_W-clpf_pkg::COEF_W){1'b0}}, cfg_reg.c1};
            end
            clpf_pkg::REG_FEEDFORWARD: begin
                prdata = {{(clpf_pkg::PDATA_W-clpf_pkg::COEF_W){1'b0}}, cfg_reg.c2};
            end
            clpf_pkg::REG_GAIN: begin
                prdata = {{(clpf_pkg::PDATA_W-clpf_pkg::GAIN_W){1'b0}}, cfg_reg.gain};
            end
            clpf_pkg::REG_ORDER: begin
                prdata = {{(clpf_pkg::PDATA_W-clpf_pkg::ORDER_W){1'b0}}, cfg_reg.order};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// File: design/clpf_mac.sv
// ----------------------------------------------------------------------------
// clpf_mac
// Shared multiplier with product/accumulator registers, floor shift and
// 32-bit saturation of one section value.
// ----------------------------------------------------------------------------
module clpf_mac (
    input  logic                                    aclk,
    input  clpf_pkg::ctrl_t                         ctrl,
    input  clpf_pkg::cfg_t                          cfg,
    input  logic signed [clpf_pkg::SAMPLE_W-1:0]    sample,
    input  logic signed [clpf_pkg::DATA_W-1:0]      hist_rd,
    input  logic signed [clpf_pkg::SUM_W-1:0]       lower_sum,
    output logic signed [clpf_pkg::DATA_W-1:0]      stage_val
);

    logic signed [clpf_pkg::OPA_W-1:0]  opa;
    logic signed [clpf_pkg::OPB_W-1:0]  opb;
    logic signed [clpf_pkg::PROD_W-1:0] prod_reg;
    logic signed [clpf_pkg::PROD_W-1:0] acc_reg;
    logic signed [clpf_pkg::ACC_W-1:0]  sum;

    always_comb begin
        case (ctrl.mul_sel)
            clpf_pkg::MUL_GAIN: begin
                opa = cfg.gain;
                opb = {{(clpf_pkg::OPB_W-clpf_pkg::SAMPLE_W){sample[clpf_pkg::SAMPLE_W-1]}},
                       sample};
            end
            clpf_pkg::MUL_FB: begin
                opa = {{(clpf_pkg::OPA_W-clpf_pkg::COEF_W){cfg.c1[clpf_pkg::COEF_W-1]}},
                       cfg.c1};
                opb = {hist_rd[clpf_pkg::DATA_W-1], hist_rd};
            end
            clpf_pkg::MUL_FF: begin
                opa = {{(clpf_pkg::OPA_W-clpf_pkg::COEF_W){1'b0}}, cfg.c2};
                opb = lower_sum;
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= opa * opb;
        end
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_load) begin
            acc_reg <= prod_reg;
        end
    end

    assign sum = {acc_reg[clpf_pkg::PROD_W-1], acc_reg}
               + {prod_reg[clpf_pkg::PROD_W-1], prod_reg};

    assign stage_val = clpf_pkg::sat32(sum[clpf_pkg::ACC_W-1:clpf_pkg::FRAC_W]);

endmodule

// File: design/clpf_ctrl.sv
// ----------------------------------------------------------------------------
// clpf_ctrl
// Sequencer stepping the shared unit through stage zero and each section.
// ----------------------------------------------------------------------------
module clpf_ctrl #(
    parameter int STAGES = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              out_free,
    input  logic [clpf_pkg::ORDER_W-1:0]      order,
    output clpf_pkg::ctrl_t                   ctrl,
    output logic [$clog2(STAGES)-1:0]         stage
);

    localparam int SW = $clog2(STAGES);
    localparam int OW = (SW > clpf_pkg::ORDER_W) ? SW : clpf_pkg::ORDER_W;

    clpf_pkg::state_t state_reg;
    clpf_pkg::state_t state_next;
    logic [SW-1:0]    stage_reg;
    logic [SW-1:0]    stage_next;
    logic [OW-1:0]    order_ext;
    logic [OW-1:0]    order_lim;
    logic [SW-1:0]    order_eff;
    logic             last;

    assign order_ext = OW'(order);
    assign order_lim = (order_ext > OW'(STAGES - 1)) ? OW'(STAGES - 1) : order_ext;
    assign order_eff = order_lim[SW-1:0];
    assign last      = (stage_reg == order_eff);
    assign stage     = stage_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            clpf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = clpf_pkg::ST_GAIN;
                end
            end
            clpf_pkg::ST_GAIN: begin
                state_next = clpf_pkg::ST_ACC;
            end
            clpf_pkg::ST_FF: begin
                state_next = clpf_pkg::ST_ACC;
            end
            clpf_pkg::ST_ACC: begin
                if (!last) begin
                    state_next = clpf_pkg::ST_FF;
                end else if (out_free) begin
                    state_next = clpf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = clpf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        ctrl.mul_sel = clpf_pkg::MUL_GAIN;
        case (state_reg)
            clpf_pkg::ST_IDLE: begin
                ctrl.in_ready  = 1'b1;
                ctrl.stage_clr = 1'b1;
            end
            clpf_pkg::ST_GAIN: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_sel   = clpf_pkg::MUL_GAIN;
                ctrl.acc_clr   = 1'b1;
                ctrl.hold_load = 1'b1;
            end
            clpf_pkg::ST_FF: begin
                ctrl.mul_en   = 1'b1;
                ctrl.mul_sel  = clpf_pkg::MUL_FF;
                ctrl.acc_load = 1'b1;
            end
            clpf_pkg::ST_ACC: begin
                ctrl.commit = 1'b1;
                if (!last) begin
                    ctrl.mul_en    = 1'b1;
                    ctrl.mul_sel   = clpf_pkg::MUL_FB;
                    ctrl.rd_next   = 1'b1;
                    ctrl.hold_load = 1'b1;
                    ctrl.stage_inc = 1'b1;
                end else begin
                    ctrl.out_load = out_free;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        stage_next = stage_reg;
        if (ctrl.stage_clr) begin
            stage_next = '0;
        end else if (ctrl.stage_inc) begin
            stage_next = stage_reg + SW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clpf_pkg::ST_IDLE;
            stage_reg <= '0;
        end else begin
            state_reg <= state_next;
            stage_reg <= stage_next;
        end
    end

endmodule

// File: design/cascaded_first_order_lowpass_unit.sv
// ----------------------------------------------------------------------------
// cascaded_first_order_lowpass_unit
// Cascade of bilinear first-order lowpass sections on a shared multiplier.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_sample[23:0], s_restart
//   m_       out        m_valid/m_ready    m_filtered[31:0]
//   apb      in         psel/penable       paddr, pwdata, prdata
//
// a beat steps through a gain state and the stage-zero ACC state, then an FF and
// an ACC state per section, as the one multiplier is shared; the unit returns to idle before the next accept
// reset clears history, configuration and handshake state
// a restart beat clears all section history at its accept
// a stalled result holds the unit on its last section until taken
// ----------------------------------------------------------------------------
module cascaded_first_order_lowpass_unit #(
    parameter int STAGES = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [clpf_pkg::ADDR_W-1:0]           paddr,
    input  logic [clpf_pkg::PDATA_W-1:0]          pwdata,
    output logic [clpf_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [clpf_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic                                  s_restart,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [clpf_pkg::DATA_W-1:0]    m_filtered
);

    localparam int SW = $clog2(STAGES);

    clpf_pkg::cfg_t                       cfg;
    clpf_pkg::ctrl_t                      ctrl;
    logic [SW-1:0]                        stage;
    logic [SW-1:0]                        rd_idx;
    logic signed [clpf_pkg::DATA_W-1:0]   hist_reg [STAGES];
    logic signed [clpf_pkg::DATA_W-1:0]   hist_rd;
    logic signed [clpf_pkg::DATA_W-1:0]   hold_reg;
    logic signed [clpf_pkg::SUM_W-1:0]    lower_sum_reg;
    logic signed [clpf_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [clpf_pkg::DATA_W-1:0]   stage_val;
    logic signed [clpf_pkg::DATA_W-1:0]   m_filtered_reg;
    logic                                 m_valid_reg;
    logic                                 out_free;
    logic                                 accept;

    clpf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clpf_ctrl #(
        .STAGES (STAGES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .order    (cfg.order),
        .ctrl     (ctrl),
        .stage    (stage)
    );

    clpf_mac u_mac (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .cfg       (cfg),
        .sample    (sample_reg),
        .hist_rd   (hist_rd),
        .lower_sum (lower_sum_reg),
        .stage_val (stage_val)
    );

    assign s_ready    = ctrl.in_ready;
    assign accept     = s_valid & ctrl.in_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;
    assign rd_idx     = ctrl.rd_next ? (stage + SW'(1)) : stage;
    assign hist_rd    = hist_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (accept && s_restart) begin
            for (int i = 0; i < STAGES; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (ctrl.commit) begin
            hist_reg[stage] <= stage_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
        end
        if (ctrl.hold_load) begin
            hold_reg <= hist_rd;
        end
        if (ctrl.commit) begin
            lower_sum_reg <= {stage_val[clpf_pkg::DATA_W-1], stage_val}
                           + {hold_reg[clpf_pkg::DATA_W-1], hold_reg};
        end
        if (ctrl.out_load) begin
            m_filtered_reg <= stage_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken beat");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a beat is in work");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |=> m_valid)
        else $error("loaded result not presented");

    a_restart_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_restart) |=> (hist_reg[STAGES-1] == '0))
        else $error("restart left history behind");
`endif

endmodule
